// ===== src/ttlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlc_pkg
// Shared constants, codes and the slot entry layout of the TTL result cache.
// ----------------------------------------------------------------------------
package ttlc_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int KEY_BITS  = 64;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int TIME_W    = 64;
    localparam int SIZE_W    = 32;
    localparam int ORDER_W   = 64;
    localparam int TOTAL_W   = 40;
    localparam int ELIM_W    = 7;
    localparam int EVC_W     = 7;
    localparam int CFG_W     = 40;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_LOOKUP  = 2'd0;
    localparam logic [1:0] OP_PUBLISH = 2'd1;
    localparam logic [1:0] OP_CLOSE   = 2'd2;

    localparam logic [2:0] ST_MISS      = 3'd0;
    localparam logic [2:0] ST_FRESH     = 3'd1;
    localparam logic [2:0] ST_STALE     = 3'd2;
    localparam logic [2:0] ST_EXPIRED   = 3'd3;
    localparam logic [2:0] ST_PUBLISHED = 3'd4;
    localparam logic [2:0] ST_REJECTED  = 3'd5;
    localparam logic [2:0] ST_CLOSED    = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BYTE_LIMIT = 2'd2;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TIME_W-1:0]   stored;
        logic [SIZE_W-1:0]   size;
        logic [ORDER_W-1:0]  order;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== src/ttlc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlc_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module ttlc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== src/ttlc_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlc_classify
// Two-stage age and freshness classification of a found entry.
// ----------------------------------------------------------------------------
module ttlc_classify (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [ttlc_pkg::TIME_W-1:0] i_stored,
    input  logic [ttlc_pkg::TIME_W-1:0] i_now,
    input  logic [ttlc_pkg::TIME_W-1:0] i_fresh,
    input  logic [ttlc_pkg::TIME_W-1:0] i_stale,
    input  logic                   i_sie,
    output logic                   o_done,
    output logic [2:0]             o_status,
    output logic [ttlc_pkg::TIME_W-1:0] o_age
);
    import ttlc_pkg::*;

    logic              r_v1;
    logic [TIME_W-1:0] r_age;
    logic [TIME_W-1:0] r_lim;
    logic [TIME_W-1:0] r_fresh;
    logic              r_sie;
    logic              r_v2;
    logic [2:0]        r_status;
    logic [TIME_W-1:0] r_age2;
    logic [TIME_W:0]   w_sum;

    assign w_sum = {1'b0, i_fresh} + {1'b0, i_stale};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
        r_age   <= (i_now >= i_stored) ? i_now - i_stored : '1;
        r_lim   <= w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];
        r_fresh <= i_fresh;
        r_sie   <= i_sie;
        r_age2  <= r_age;
        if (r_age < r_fresh) begin
            r_status <= ST_FRESH;
        end else if (r_sie && (r_age < r_lim)) begin
            r_status <= ST_STALE;
        end else begin
            r_status <= ST_EXPIRED;
        end
    end

    assign o_done   = r_v2;
    assign o_status = r_status;
    assign o_age    = r_age2;
endmodule

// ===== src/ttl_result_cache_fifo_evict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_result_cache_fifo_evict
// Keyed TTL result cache with FIFO eviction over a slot memory.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Entry data lives in a one-port-read RAM of
// NUM_SLOTS rows; valid bits are flip-flops. Every RAM scan reads all NUM_SLOTS
// rows. A lookup scans once, then classifies the found entry and posts the
// result. A publish scans once for key and free slot, writes, checks the
// limits and posts. A new key on a full table adds an oldest-entry scan, and
// each eviction over a limit adds a scan and a recheck. Close, rejected
// publishes and lookups that skip the scan go straight to the result. A held
// output stretches the result cycle. A new item is taken while a result still
// waits on the output.
// ----------------------------------------------------------------------------
module ttl_result_cache_fifo_evict (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_idx,
    input  logic [39:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // key_tag[63:0], now_ms[127:64], byte_size[159:128], policy_enabled[160],
    // fresh_ms[224:161], stale_ms[288:225], allow_stale[289], zero pad
    input  logic [295:0]  s_axis_tdata,
    // op[1:0]
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // slot[5:0], age_ms[69:6], evicted_count[76:70], zero pad
    output logic [79:0]   m_axis_tdata,
    // status[2:0]
    output logic [2:0]    m_axis_tuser
);
    import ttlc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LSCAN = 4'd1;
    localparam logic [3:0] S_LCLS  = 4'd2;
    localparam logic [3:0] S_PSCAN = 4'd3;
    localparam logic [3:0] S_OSCAN = 4'd4;
    localparam logic [3:0] S_WRITE = 4'd5;
    localparam logic [3:0] S_CHECK = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;
    localparam logic [3:0] S_CSTRT = 4'd8;

    logic [3:0]           r_state;
    logic [ELIM_W-1:0]    r_entry_limit;
    logic [TOTAL_W-1:0]   r_byte_limit;
    logic [SIZE_W-1:0]    r_entry_byte_limit;

    logic [NUM_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]     r_cnt;
    logic [TOTAL_W-1:0]   r_total;
    logic [ORDER_W-1:0]   r_next_order;
    logic                 r_closed;

    logic [KEY_BITS-1:0]  r_key;
    logic [TIME_W-1:0]    r_now;
    logic [SIZE_W-1:0]    r_bytes;
    logic [TIME_W-1:0]    r_fresh;
    logic [TIME_W-1:0]    r_stale;
    logic                 r_sie;

    logic [CNT_W-1:0]     r_idx;
    logic                 r_pend;
    logic [SLOT_W-1:0]    r_pidx;

    logic                 r_found;
    logic [SLOT_W-1:0]    r_fslot;
    logic [TIME_W-1:0]    r_ftime;
    logic [SIZE_W-1:0]    r_fsize;
    logic                 r_free_found;
    logic [SLOT_W-1:0]    r_free_slot;
    logic                 r_best_found;
    logic [SLOT_W-1:0]    r_best_slot;
    logic [ORDER_W-1:0]   r_best_order;
    logic [SIZE_W-1:0]    r_best_size;
    logic                 r_evw;
    logic [SLOT_W-1:0]    r_wslot;

    logic [2:0]           r_res_status;
    logic [SLOT_W-1:0]    r_res_slot;
    logic [TIME_W-1:0]    r_res_age;
    logic [EVC_W-1:0]     r_res_evc;

    logic                 r_ovalid;
    logic [2:0]           r_o_status;
    logic [SLOT_W-1:0]    r_o_slot;
    logic [TIME_W-1:0]    r_o_age;
    logic [EVC_W-1:0]     r_o_evc;

    logic                 w_in_acc;
    logic                 w_scanning;
    logic                 w_issue;
    logic                 w_scan_end;
    logic                 w_pvalid;
    logic                 w_we;
    t_entry               w_wentry;
    t_entry               w_rd;
    logic                 w_cls_start;
    logic                 w_cls_done;
    logic [2:0]           w_cls_status;
    logic [TIME_W-1:0]    w_cls_age;
    logic                 w_out_free;

    logic [1:0]           w_op;
    logic [KEY_BITS-1:0]  w_key;
    logic [SIZE_W-1:0]    w_bytes;
    logic                 w_policy;

    assign w_op     = s_axis_tuser;
    assign w_key    = s_axis_tdata[KEY_BITS-1:0];
    assign w_bytes  = s_axis_tdata[159:128];
    assign w_policy = s_axis_tdata[160];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ovalid || m_axis_tready;

    assign w_scanning = (r_state == S_LSCAN) || (r_state == S_PSCAN) ||
                        (r_state == S_OSCAN);
    assign w_issue    = w_scanning && (r_idx < CNT_W'(NUM_SLOTS));
    assign w_scan_end = w_scanning && !w_issue && !r_pend;
    assign w_pvalid   = r_pend && r_valid[r_pidx];

    assign w_we            = (r_state == S_WRITE);
    assign w_wentry.key    = r_key;
    assign w_wentry.stored = r_now;
    assign w_wentry.size   = r_bytes;
    assign w_wentry.order  = r_next_order;

    ttlc_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wslot),
        .i_wdata (w_wentry),
        .i_re    (w_issue),
        .i_raddr (r_idx[SLOT_W-1:0]),
        .o_rdata (w_rd)
    );

    assign w_cls_start = (r_state == S_CSTRT);

    ttlc_classify u_cls (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_cls_start),
        .i_stored (r_ftime),
        .i_now    (r_now),
        .i_fresh  (r_fresh),
        .i_stale  (r_stale),
        .i_sie    (r_sie),
        .o_done   (w_cls_done),
        .o_status (w_cls_status),
        .o_age    (w_cls_age)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_entry_limit      <= 7'd64;
            r_byte_limit       <= 40'd1073741824;
            r_entry_byte_limit <= 32'd16777216;
            r_valid            <= '0;
            r_cnt              <= '0;
            r_total            <= '0;
            r_next_order       <= '0;
            r_closed           <= 1'b0;
            r_pend             <= 1'b0;
            r_ovalid           <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_ENTRY_LIMIT:      r_entry_limit      <= i_cfg_data[ELIM_W-1:0];
                    CFG_BYTE_LIMIT:       r_byte_limit       <= i_cfg_data[TOTAL_W-1:0];
                    CFG_ENTRY_BYTE_LIMIT: r_entry_byte_limit <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            if ((r_state == S_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            if (w_scanning) begin
                if (w_issue) begin
                    r_idx  <= r_idx + CNT_W'(1);
                    r_pend <= 1'b1;
                    r_pidx <= r_idx[SLOT_W-1:0];
                end else begin
                    r_pend <= 1'b0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    r_idx        <= '0;
                    r_pend       <= 1'b0;
                    r_found      <= 1'b0;
                    r_free_found <= 1'b0;
                    r_best_found <= 1'b0;
                    r_evw        <= 1'b0;
                    r_res_status <= ST_MISS;
                    r_res_slot   <= '0;
                    r_res_age    <= '0;
                    r_res_evc    <= '0;
                    if (w_in_acc) begin
                        r_key   <= w_key;
                        r_now   <= s_axis_tdata[127:64];
                        r_bytes <= w_bytes;
                        r_fresh <= s_axis_tdata[224:161];
                        r_stale <= s_axis_tdata[288:225];
                        r_sie   <= s_axis_tdata[289];
                        case (w_op)
                            OP_LOOKUP: begin
                                r_state <= (w_policy && !r_closed) ? S_LSCAN : S_DONE;
                            end
                            OP_PUBLISH: begin
                                if (r_closed || (w_bytes > r_entry_byte_limit) ||
                                    (TOTAL_W'(w_bytes) > r_byte_limit)) begin
                                    r_res_status <= ST_REJECTED;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_state <= S_PSCAN;
                                end
                            end
                            OP_CLOSE: begin
                                r_closed     <= 1'b1;
                                r_valid      <= '0;
                                r_cnt        <= '0;
                                r_total      <= '0;
                                r_res_status <= ST_CLOSED;
                                r_state      <= S_DONE;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_LSCAN: begin
                    if (w_pvalid && !r_found && (w_rd.key == r_key)) begin
                        r_found <= 1'b1;
                        r_fslot <= r_pidx;
                        r_ftime <= w_rd.stored;
                    end
                    if (w_scan_end) begin
                        r_state <= r_found ? S_CSTRT : S_DONE;
                    end
                end
                S_CSTRT: begin
                    r_state <= S_LCLS;
                end
                S_LCLS: begin
                    if (w_cls_done) begin
                        r_res_status <= w_cls_status;
                        r_res_age    <= w_cls_age;
                        r_res_slot   <= (w_cls_status == ST_EXPIRED) ? '0 : r_fslot;
                        r_state      <= S_DONE;
                    end
                end
                S_PSCAN: begin
                    if (w_pvalid && !r_found && (w_rd.key == r_key)) begin
                        r_found <= 1'b1;
                        r_fslot <= r_pidx;
                        r_fsize <= w_rd.size;
                    end
                    if (r_pend && !r_valid[r_pidx] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_slot  <= r_pidx;
                    end
                    if (w_scan_end) begin
                        if (r_found) begin
                            r_total <= r_total - TOTAL_W'(r_fsize);
                            r_wslot <= r_fslot;
                            r_state <= S_WRITE;
                        end else if (r_free_found) begin
                            r_wslot <= r_free_slot;
                            r_state <= S_WRITE;
                        end else begin
                            r_idx   <= '0;
                            r_evw   <= 1'b0;
                            r_state <= S_OSCAN;
                        end
                    end
                end
                S_OSCAN: begin
                    if (w_pvalid && (!r_best_found || (w_rd.order < r_best_order))) begin
                        r_best_found <= 1'b1;
                        r_best_slot  <= r_pidx;
                        r_best_order <= w_rd.order;
                        r_best_size  <= w_rd.size;
                    end
                    if (w_scan_end) begin
                        if (r_best_found) begin
                            r_valid[r_best_slot] <= 1'b0;
                            r_cnt                <= r_cnt - CNT_W'(1);
                            r_total              <= r_total - TOTAL_W'(r_best_size);
                            r_res_evc            <= r_res_evc + EVC_W'(1);
                        end
                        if (!r_evw) begin
                            r_wslot <= r_best_slot;
                        end
                        r_state <= r_evw ? S_CHECK : S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_valid[r_wslot] <= 1'b1;
                    if (!r_found) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    r_total      <= r_total + TOTAL_W'(r_bytes);
                    r_next_order <= r_next_order + ORDER_W'(1);
                    r_state      <= S_CHECK;
                end
                S_CHECK: begin
                    if ((r_cnt != '0) && ((r_cnt > r_entry_limit) ||
                                          (r_total > r_byte_limit))) begin
                        r_idx        <= '0;
                        r_pend       <= 1'b0;
                        r_best_found <= 1'b0;
                        r_evw        <= 1'b1;
                        r_state      <= S_OSCAN;
                    end else begin
                        r_res_status <= ST_PUBLISHED;
                        r_res_slot   <= r_wslot;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_status <= r_res_status;
                        r_o_slot   <= r_res_slot;
                        r_o_age    <= r_res_age;
                        r_o_evc    <= r_res_evc;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {3'b000, r_o_evc, r_o_age, r_o_slot};

    a_cnt_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CNT_W'($countones(r_valid)))
        else $error("entry count out of step with valid bits");

    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |-> (r_valid == '0) && (r_total == '0))
        else $error("closed cache holds entries");

    a_idle_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && $past(r_state == S_DONE) && (r_res_status == ST_PUBLISHED)
        |-> (r_cnt <= r_entry_limit) && (r_total <= r_byte_limit))
        else $error("publish left cache over its limits");
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TTL result cache with FIFO eviction: a directed
// table, then random lookups and publishes under several limit settings, a
// close tail, random gaps on both streams and one long output hold-off; every
// result is compared field by field with its table row or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
    import ttlc_pkg::*;

    localparam int LIMIT_CYCLES = 20_000_000;
    localparam int DRAIN_CYCLES = 5000;
    localparam int NPH          = 6;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] key;
        logic [63:0] now;
        logic [31:0] bytes;
        logic        en;
        logic [63:0] fresh;
        logic [63:0] stale;
        logic        sie;
    } t_req;

    typedef struct {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [63:0] age;
        logic [6:0]  evc;
    } t_res;

    typedef struct {
        t_req r;
        bit   typed;
        t_res x;
    } t_row;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          i_cfg_wr_en = 0;
    logic [1:0]    i_cfg_idx = '0;
    logic [39:0]   i_cfg_data = '0;
    logic          s_axis_tvalid = 0;
    logic          s_axis_tready;
    logic [295:0]  s_axis_tdata = '0;
    logic [1:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 0;
    logic [79:0]   m_axis_tdata;
    logic [2:0]    m_axis_tuser;

    ttl_result_cache_fifo_evict dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // predictor state
    bit          c_valid [NUM_SLOTS];
    logic [63:0] c_key   [NUM_SLOTS];
    logic [63:0] c_time  [NUM_SLOTS];
    logic [31:0] c_size  [NUM_SLOTS];
    logic [63:0] c_ord   [NUM_SLOTS];
    logic [63:0] c_total;
    logic [63:0] c_next;
    bit          c_closed;
    logic [6:0]  lim_entries;
    logic [39:0] lim_bytes;
    logic [31:0] lim_entry_bytes;

    t_res pending [$];
    int   errors;
    int   results_seen;
    int   cycles;
    t_row rows [$];
    logic [63:0] clk_ms;

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic evict_oldest();
        int old;
        old = -1;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (c_valid[i] && (old < 0 || c_ord[i] < c_ord[old]))
                old = i;
        if (old >= 0) begin
            c_valid[old] = 0;
            c_total -= c_size[old];
        end
    endtask

    function automatic int find_key(input logic [63:0] k);
        for (int i = 0; i < NUM_SLOTS; i++)
            if (c_valid[i] && c_key[i] == k)
                return i;
        return -1;
    endfunction

    task automatic cache_apply(input t_req r, output bit has, output t_res o);
        int s;
        int n;
        logic [64:0] lim;
        o = '{default: '0};
        has = (r.op != OP_NONE);
        if (r.op == OP_CLOSE) begin
            c_closed = 1;
            foreach (c_valid[i]) c_valid[i] = 0;
            c_total = 0;
            o.status = ST_CLOSED;
        end else if (r.op == OP_LOOKUP) begin
            o.status = ST_MISS;
            s = (r.en && !c_closed) ? find_key(r.key) : -1;
            if (s >= 0) begin
                o.age = (r.now >= c_time[s]) ? r.now - c_time[s] : '1;
                lim = {1'b0, r.fresh} + {1'b0, r.stale};
                if (lim[64]) lim = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
                if (o.age < r.fresh) begin
                    o.status = ST_FRESH;
                    o.slot = s[5:0];
                end else if (r.sie && {1'b0, o.age} < lim) begin
                    o.status = ST_STALE;
                    o.slot = s[5:0];
                end else begin
                    o.status = ST_EXPIRED;
                end
            end
        end else if (r.op == OP_PUBLISH) begin
            if (c_closed || r.bytes > lim_entry_bytes || {8'd0, r.bytes} > lim_bytes) begin
                o.status = ST_REJECTED;
            end else begin
                s = find_key(r.key);
                if (s >= 0) begin
                    c_total -= c_size[s];
                end else begin
                    for (int i = 0; i < NUM_SLOTS && s < 0; i++)
                        if (!c_valid[i]) s = i;
                    if (s < 0) begin
                        evict_oldest();
                        o.evc++;
                        for (int i = 0; i < NUM_SLOTS && s < 0; i++)
                            if (!c_valid[i]) s = i;
                    end
                end
                c_valid[s] = 1;
                c_key[s] = r.key;
                c_time[s] = r.now;
                c_size[s] = r.bytes;
                c_ord[s] = c_next;
                c_next++;
                c_total += r.bytes;
                n = 0;
                foreach (c_valid[i]) n += c_valid[i];
                while (n > 0 && (n > lim_entries || c_total > {24'd0, lim_bytes})) begin
                    evict_oldest();
                    o.evc++;
                    n--;
                end
                o.status = ST_PUBLISHED;
                o.slot = s[5:0];
            end
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [39:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 0;
        case (idx)
            CFG_ENTRY_LIMIT:      lim_entries = val[6:0];
            CFG_BYTE_LIMIT:       lim_bytes = val;
            CFG_ENTRY_BYTE_LIMIT: lim_entry_bytes = val[31:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input t_req r, input bit typed, input t_res tx);
        bit   has;
        t_res o;
        int   g;
        g = $urandom_range(0, 99);
        if (g >= 55) repeat (g >= 97 ? $urandom_range(20, 80) : $urandom_range(1, 3))
            @(negedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tuser <= r.op;
        s_axis_tdata <= {6'd0, r.sie, r.stale, r.fresh, r.en, r.bytes, r.now, r.key};
        do @(posedge i_clk); while (!s_axis_tready);
        cache_apply(r, has, o);
        if (has) pending.push_back(typed ? tx : o);
        @(negedge i_clk);
        s_axis_tvalid <= 0;
    endtask

    task automatic drain();
        while (pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_row mk(input logic [1:0] op, input logic [63:0] key,
                                input logic [63:0] now, input logic [31:0] bytes,
                                input logic en, input logic [63:0] fresh,
                                input logic [63:0] stale, input logic sie,
                                input bit typed, input logic [2:0] st,
                                input logic [5:0] slot, input logic [63:0] age,
                                input logic [6:0] evc);
        t_row w;
        w.r = '{op, key, now, bytes, en, fresh, stale, sie};
        w.typed = typed;
        w.x = '{st, slot, age, evc};
        return w;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req rand_req(input int pool, input logic [31:0] bmax);
        t_req r;
        int   p;
        p = $urandom_range(0, 99);
        r.op = (p < 45) ? OP_LOOKUP : (p < 93) ? OP_PUBLISH : OP_NONE;
        r.key = ($urandom_range(0, 99) < 95) ? 64'($urandom_range(0, pool - 1)) : rnd64();
        clk_ms += $urandom_range(0, 40);
        r.now = ($urandom_range(0, 99) < 4) ? rnd64() : clk_ms;
        r.bytes = ($urandom_range(0, 99) < 90) ? $urandom_range(0, bmax) : $urandom;
        r.en = ($urandom_range(0, 99) < 90);
        r.fresh = ($urandom_range(0, 99) < 80) ? 64'($urandom_range(0, 150)) : rnd64();
        r.stale = ($urandom_range(0, 99) < 80) ? 64'($urandom_range(0, 150)) : rnd64();
        r.sie = $urandom_range(0, 1);
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res x;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending.size() == 0) begin
                report("result with nothing pending");
            end else begin
                x = pending.pop_front();
                if (m_axis_tuser !== x.status)
                    report($sformatf("status %0d want %0d", m_axis_tuser, x.status));
                if (m_axis_tdata[5:0] !== x.slot)
                    report($sformatf("slot %0d want %0d", m_axis_tdata[5:0], x.slot));
                if (m_axis_tdata[69:6] !== x.age)
                    report($sformatf("age %0h want %0h", m_axis_tdata[69:6], x.age));
                if (m_axis_tdata[76:70] !== x.evc)
                    report($sformatf("evicted %0d want %0d", m_axis_tdata[76:70], x.evc));
            end
        end
    end

    // output ready: short and long stalls, one long hold-off
    initial begin
        bit held;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 30) begin
                held = 1;
                m_axis_tready <= 0;
                repeat (400) @(negedge i_clk);
            end
            if ($urandom_range(0, 99) < 60) begin
                m_axis_tready <= 1;
            end else begin
                m_axis_tready <= 0;
                repeat ($urandom_range(0, 99) < 95 ? $urandom_range(0, 3)
                        : $urandom_range(20, 60)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [6:0]  ph_el [NPH];
        logic [39:0] ph_bl [NPH];
        logic [31:0] ph_eb [NPH];
        logic [31:0] ph_bm [NPH];
        int          ph_n  [NPH];
        int          ph_kp [NPH];
        logic [63:0] ones;
        t_req        r;
        t_res        none;
        int          cnt;
        ph_el = '{7'd64, 7'd4, 7'd127, 7'd0, 7'd1, 7'd64};
        ph_bl = '{40'd1 << 30, 40'd1000, '1, 40'd1 << 30, 40'd1, 40'd5000};
        ph_eb = '{32'd1 << 24, 32'd2000, '1, 32'd1 << 24, 32'd1, 32'd2000};
        ph_bm = '{32'd3000, 32'd1500, '1, 32'd100, 32'd2, 32'd2500};
        ph_n  = '{200, 150, 200, 50, 50, 200};
        ph_kp = '{32, 8, 100, 8, 4, 40};
        ones = '1;
        none = '{default: '0};
        errors = 0;
        results_seen = 0;
        cycles = 0;
        clk_ms = 64'd1000;
        foreach (c_valid[i]) c_valid[i] = 0;
        c_total = 0;
        c_next = 0;
        c_closed = 0;
        lim_entries = 7'd64;
        lim_bytes = 40'd1 << 30;
        lim_entry_bytes = 32'd1 << 24;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;

        rows.push_back(mk(OP_LOOKUP, 0, 10, 0, 1, 5, 5, 1, 1, ST_MISS, 0, 0, 0));
        rows.push_back(mk(OP_PUBLISH, 0, 100, 10, 0, 0, 0, 0, 1, ST_PUBLISHED, 0, 0, 0));
        rows.push_back(mk(OP_LOOKUP, 0, 150, 0, 1, 100, 0, 0, 1, ST_FRESH, 0, 50, 0));
        rows.push_back(mk(OP_LOOKUP, 0, 50, 0, 1, ones, ones, 1, 1, ST_EXPIRED, 0, ones, 0));
        rows.push_back(mk(OP_LOOKUP, 0, 150, 0, 0, 100, 0, 0, 1, ST_MISS, 0, 0, 0));
        rows.push_back(mk(OP_PUBLISH, 5, 100, (32'd1 << 24) + 1, 1, 0, 0, 0,
                          1, ST_REJECTED, 0, 0, 0));
        rows.push_back(mk(OP_PUBLISH, ones, ones, 32'd1 << 24, 1, ones, ones, 1,
                          1, ST_PUBLISHED, 1, 0, 0));
        rows.push_back(mk(OP_LOOKUP, ones, ones, 0, 1, 0, 5, 1, 1, ST_STALE, 1, 0, 0));
        rows.push_back(mk(OP_NONE, ones, ones, ones, 1, ones, ones, 1, 0, ST_MISS, 0, 0, 0));
        rows.push_back(mk(OP_LOOKUP, 0, 300, 0, 1, 100, 50, 0, 1, ST_EXPIRED, 0, 200, 0));
        rows.push_back(mk(OP_LOOKUP, 0, 300, 0, 1, 100, 150, 1, 0, ST_MISS, 0, 0, 0));
        rows.push_back(mk(OP_PUBLISH, 0, 400, 0, 0, 0, 0, 0, 1, ST_PUBLISHED, 0, 0, 0));
        rows.push_back(mk(OP_PUBLISH, 7, 400, ones[31:0], 1, 0, 0, 0,
                          1, ST_REJECTED, 0, 0, 0));
        rows.push_back(mk(OP_LOOKUP, 7, 400, 0, 1, 9, 9, 1, 1, ST_MISS, 0, 0, 0));
        foreach (rows[i]) send_item(rows[i].r, rows[i].typed, rows[i].x);

        for (int p = 0; p < NPH; p++) begin
            drain();
            cfg_write(CFG_ENTRY_LIMIT, {33'd0, ph_el[p]});
            cfg_write(CFG_BYTE_LIMIT, ph_bl[p]);
            cfg_write(CFG_ENTRY_BYTE_LIMIT, {8'd0, ph_eb[p]});
            cnt = 0;
            while (cnt < ph_n[p]) begin
                r = rand_req(ph_kp[p], ph_bm[p]);
                send_item(r, 0, none);
                cnt++;
            end
        end

        // close tail: lookups miss and publishes are rejected afterward
        rows.delete();
        rows.push_back(mk(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0, 1, ST_CLOSED, 0, 0, 0));
        rows.push_back(mk(OP_CLOSE, ones, ones, 5, 1, 0, 0, 1, 1, ST_CLOSED, 0, 0, 0));
        rows.push_back(mk(OP_LOOKUP, 1, clk_ms, 0, 1, ones, 0, 1, 1, ST_MISS, 0, 0, 0));
        rows.push_back(mk(OP_PUBLISH, 1, clk_ms, 1, 1, 0, 0, 0, 1, ST_REJECTED, 0, 0, 0));
        foreach (rows[i]) send_item(rows[i].r, rows[i].typed, rows[i].x);
        for (int i = 0; i < 10; i++) send_item(rand_req(8, 100), 0, none);

        while (pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
